// File: sv/kpd_pkg.sv
`default_nettype none

package kpd_pkg;

    localparam int NUM_KEYS   = 2;
    localparam int CNT_W      = 16;
    localparam int SEL_W      = 1;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    localparam logic CMD_SCAN = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [1:0] REG_HOLD_COUNT    = 2'd0;
    localparam logic [1:0] REG_MAX_COUNT     = 2'd1;
    localparam logic [1:0] REG_INITIAL_FLAGS = 2'd2;

    localparam logic [CNT_W-1:0]    HOLD_COUNT_RST    = CNT_W'(10);
    localparam logic [CNT_W-1:0]    MAX_COUNT_RST     = CNT_W'(100);
    localparam logic [NUM_KEYS-1:0] INITIAL_FLAGS_RST = '0;

    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [NUM_KEYS-1:0] keys_t;

    typedef struct packed {
        cnt_t  hold_count;
        cnt_t  max_count;
        logic  flag_load;
        keys_t flag_value;
    } cfg_t;

endpackage

`default_nettype wire

// File: sv/kpd_if.sv
`default_nettype none

interface kpd_in_if;
    logic                       valid;
    logic                       ready;
    logic                       command;
    logic [kpd_pkg::NUM_KEYS-1:0] key_levels;
    logic [kpd_pkg::SEL_W-1:0]    key_select;

    modport source (output valid, output command, output key_levels, output key_select,
                    input ready);
    modport sink (input valid, input command, input key_levels, input key_select,
                  output ready);
endinterface

interface kpd_out_if;
    logic                       valid;
    logic                       ready;
    logic                       key_down;
    logic [kpd_pkg::NUM_KEYS-1:0] flag_vector;

    modport source (output valid, output key_down, output flag_vector, input ready);
    modport sink (input valid, input key_down, input flag_vector, output ready);
endinterface

`default_nettype wire

// File: sv/kpd_cfg.sv
`default_nettype none

module kpd_cfg (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [kpd_pkg::ADDR_W-1:0] paddr,
    input  wire logic [kpd_pkg::DATA_W-1:0] pwdata,
    output logic      [kpd_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output kpd_pkg::cfg_t                   cfg
);
    import kpd_pkg::*;

    cnt_t  hold_count_reg;
    cnt_t  max_count_reg;
    keys_t initial_flags_reg;
    logic  wr_en;
    logic  addr_ok;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign addr_ok = (paddr[1:0] == 2'b00);
    assign wr_en   = psel && penable && pwrite && pready && addr_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_count_reg    <= HOLD_COUNT_RST;
            max_count_reg     <= MAX_COUNT_RST;
            initial_flags_reg <= INITIAL_FLAGS_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_HOLD_COUNT:    hold_count_reg    <= pwdata[CNT_W-1:0];
                REG_MAX_COUNT:     max_count_reg     <= pwdata[CNT_W-1:0];
                REG_INITIAL_FLAGS: initial_flags_reg <= pwdata[NUM_KEYS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        if (addr_ok)
        begin
            case (reg_idx)
                REG_HOLD_COUNT:    prdata = DATA_W'(hold_count_reg);
                REG_MAX_COUNT:     prdata = DATA_W'(max_count_reg);
                REG_INITIAL_FLAGS: prdata = DATA_W'(initial_flags_reg);
                default:           prdata = '0;
            endcase
        end
    end

    assign cfg.hold_count = hold_count_reg;
    assign cfg.max_count  = max_count_reg;
    assign cfg.flag_load  = wr_en && (reg_idx == REG_INITIAL_FLAGS);
    assign cfg.flag_value = pwdata[NUM_KEYS-1:0];

endmodule

`default_nettype wire

// File: sv/kpd_core.sv
`default_nettype none

module kpd_core (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire kpd_pkg::cfg_t cfg,
    kpd_in_if.sink       in_ch,
    kpd_out_if.source    out_ch
);
    import kpd_pkg::*;

    logic              in_valid_reg;
    logic              command_reg;
    keys_t             levels_reg;
    logic [SEL_W-1:0]  select_reg;

    logic              out_valid_reg;
    logic              key_down_reg;
    keys_t             flag_vector_reg;

    cnt_t              cnt_reg  [NUM_KEYS];
    cnt_t              cnt_next [NUM_KEYS];
    keys_t             flags_reg;
    keys_t             flags_next;
    logic              down_next;
    logic              advance;
    keys_t             active;

    assign advance      = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !in_valid_reg || advance;

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.key_down    = key_down_reg;
    assign out_ch.flag_vector = flag_vector_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            command_reg <= in_ch.command;
            levels_reg  <= in_ch.key_levels;
            select_reg  <= in_ch.key_select;
        end
    end

    // Only the highest-numbered pressed key is treated as pressed.
    always_comb
    begin
        active = '0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            if (levels_reg[k])
            begin
                active = keys_t'(1) << k;
            end
        end
    end

    always_comb
    begin
        flags_next = flags_reg;
        down_next  = 1'b0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            cnt_next[k] = cnt_reg[k];
        end
        if (command_reg == CMD_SCAN)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                if (active[k])
                begin
                    if (cnt_reg[k] != '1)
                    begin
                        cnt_next[k] = cnt_reg[k] + cnt_t'(1);
                    end
                end
                else
                begin
                    cnt_next[k]   = '0;
                    flags_next[k] = 1'b0;
                end
                if (cnt_next[k] == cfg.hold_count)
                begin
                    flags_next[k] = 1'b1;
                end
                if (cnt_next[k] > cfg.max_count)
                begin
                    cnt_next[k]   = '0;
                    flags_next[k] = 1'b0;
                end
            end
        end
        else
        begin
            down_next              = flags_reg[select_reg];
            flags_next[select_reg] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                cnt_reg[k] <= '0;
            end
        end
        else if (cfg.flag_load)
        begin
            flags_reg <= cfg.flag_value;
        end
        else if (advance)
        begin
            flags_reg <= flags_next;
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                cnt_reg[k] <= cnt_next[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            key_down_reg    <= down_next;
            flag_vector_reg <= flags_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/key_press_debouncer.sv
// Path: input transaction -> input register -> result register.
// Throughput: one transaction per cycle unless the output stalls; the key state is
// updated in a single pass between the input register and the result register.
// Reset: rst_n is asynchronous and active low; it clears all counters and flags and
// loads the register reset values (hold count 10, max count 100, initial flags 0).
`default_nettype none

module key_press_debouncer (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    kpd_in_if.sink                          in_ch,
    kpd_out_if.source                       out_ch,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [kpd_pkg::ADDR_W-1:0] paddr,
    input  wire logic [kpd_pkg::DATA_W-1:0] pwdata,
    output logic      [kpd_pkg::DATA_W-1:0] prdata,
    output logic                            pready
);
    import kpd_pkg::*;

    cfg_t cfg;

    kpd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    kpd_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

endmodule

`default_nettype wire

// File: sv/kpd_checker.sv
`default_nettype none

module kpd_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_valid,
    input wire logic                         in_ready,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic                         out_key_down,
    input wire logic [kpd_pkg::NUM_KEYS-1:0] out_flag_vector
);

    // A stalled result holds its place.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_key_down) && $stable(out_flag_vector))
        else $error("result changed while stalled");

    // The input only stalls when a finished result is waiting downstream.
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with an empty output");

    // A new result always comes from an input transaction taken earlier, via the input register.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without a matching input transaction");

endmodule

bind key_press_debouncer kpd_checker u_kpd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_key_down    (out_ch.key_down),
    .out_flag_vector (out_ch.flag_vector)
);

`default_nettype wire

// File: bench/tb_key_press_debouncer.sv
`timescale 1ns / 1ps

module tb_key_press_debouncer;
    import kpd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 85;

    typedef struct packed {
        logic  key_down;
        keys_t flag_vector;
    } key_status_t;

    class key_flag_tracker;
        cnt_t        hold_count;
        cnt_t        max_count;
        keys_t       flags;
        cnt_t        counters [NUM_KEYS];
        key_status_t awaited_status [$];
        int          mismatches;

        function new();
            hold_count = HOLD_COUNT_RST;
            max_count  = MAX_COUNT_RST;
            flags      = INITIAL_FLAGS_RST;
            foreach (counters[k])
                counters[k] = '0;
            mismatches = 0;
        endfunction

        function void load_register(logic [1:0] index, logic [DATA_W-1:0] value);
            case (index)
                REG_HOLD_COUNT:    hold_count = value[CNT_W-1:0];
                REG_MAX_COUNT:     max_count = value[CNT_W-1:0];
                REG_INITIAL_FLAGS: flags = value[NUM_KEYS-1:0];
                default: ;
            endcase
        endfunction

        function void take_item(logic command, keys_t levels, logic [SEL_W-1:0] select);
            int          active;
            key_status_t status;
            status.key_down = 1'b0;
            if (command == CMD_SCAN)
            begin
                // Only the highest-numbered pressed key counts as pressed.
                active = 0;
                for (int k = 0; k < NUM_KEYS; k++)
                    if (levels[k])
                        active = k + 1;
                for (int k = 0; k < NUM_KEYS; k++)
                begin
                    if (k + 1 == active)
                    begin
                        if (counters[k] != '1)
                            counters[k] = counters[k] + 1'b1;
                    end
                    else
                    begin
                        counters[k] = '0;
                        flags[k] = 1'b0;
                    end
                    if (counters[k] == hold_count)
                        flags[k] = 1'b1;
                    if (counters[k] > max_count)
                    begin
                        counters[k] = '0;
                        flags[k] = 1'b0;
                    end
                end
            end
            else if (int'(select) < NUM_KEYS)
            begin
                status.key_down = flags[select];
                flags[select] = 1'b0;
            end
            status.flag_vector = flags;
            awaited_status.push_back(status);
        endfunction

        function void note_mismatch(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: %s", what);
        endfunction

        function void match_result(logic key_down, keys_t flag_vector);
            key_status_t want;
            if (awaited_status.size() == 0)
            begin
                note_mismatch($sformatf("unexpected transaction key_down=%0b flag_vector=%b",
                                        key_down, flag_vector));
            end
            else
            begin
                want = awaited_status.pop_front();
                if (key_down !== want.key_down)
                    note_mismatch($sformatf("key_down expected %0b actual %0b",
                                            want.key_down, key_down));
                if (flag_vector !== want.flag_vector)
                    note_mismatch($sformatf("flag_vector expected %b actual %b",
                                            want.flag_vector, flag_vector));
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              calm = 1'b0;
    int                quiet_cycles = 0;
    key_flag_tracker   tracker;

    cnt_t hold_plan [PHASES] = '{16'd1, 16'd1, 16'd65534, 16'd5, 16'd3, 16'd10, 16'd4, 16'd2};
    cnt_t max_plan [PHASES] = '{16'd1, 16'd65534, 16'd65534, 16'd2, 16'd8, 16'd100, 16'd9,
                                16'd65534};

    kpd_in_if  in_ch ();
    kpd_out_if out_ch ();

    key_press_debouncer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_key_press_debouncer: errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_register(logic [1:0] index, logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({index, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        tracker.load_register(index, value);
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        while (tracker.awaited_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(cnt_t hold, cnt_t limit, keys_t start_flags);
        settle();
        write_register(REG_HOLD_COUNT, DATA_W'(hold));
        write_register(REG_MAX_COUNT, DATA_W'(limit));
        write_register(REG_INITIAL_FLAGS, DATA_W'(start_flags));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_item(logic command, keys_t levels, logic [SEL_W-1:0] select);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.command    <= command;
        in_ch.key_levels <= levels;
        in_ch.key_select <= select;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        tracker.take_item(command, levels, select);
    endtask

    task automatic scan(keys_t levels);
        send_item(CMD_SCAN, levels, SEL_W'($urandom_range(0, 1)));
    endtask

    task automatic read_flag(logic [SEL_W-1:0] select);
        send_item(CMD_READ, keys_t'($urandom_range(0, 3)), select);
    endtask

    task automatic random_phase(int count);
        int    sent;
        int    span;
        int    run;
        keys_t held;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                send_item(1'($urandom_range(0, 1)), keys_t'($urandom_range(0, 3)),
                          SEL_W'($urandom_range(0, 1)));
                sent++;
            end
            else
            begin
                // Hold one key pattern for a random run; it may reach the set counts.
                held = keys_t'($urandom_range(1, 3));
                if (int'(tracker.max_count) + 3 <= 40)
                    span = int'(tracker.max_count) + 3;
                else if (int'(tracker.hold_count) + 3 <= 40)
                    span = int'(tracker.hold_count) + 3;
                else
                    span = 40;
                run = $urandom_range(1, span);
                repeat (run)
                begin
                    scan(held);
                    sent++;
                    if ($urandom_range(0, 4) == 0)
                    begin
                        read_flag(SEL_W'($urandom_range(0, 1)));
                        sent++;
                    end
                end
                if ($urandom_range(0, 1) == 1)
                begin
                    scan('0);
                    sent++;
                end
                read_flag(SEL_W'($urandom_range(0, 1)));
                read_flag(SEL_W'($urandom_range(0, 1)));
                sent += 2;
            end
        end
    endtask

    initial
    begin
        int stall;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (out_ch.valid !== 1'b1);
            tracker.match_result(out_ch.key_down, out_ch.flag_vector);
        end
    end

    initial
    begin
        tracker = new();
        rst_n            <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.command    <= CMD_SCAN;
        in_ch.key_levels <= '0;
        in_ch.key_select <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        read_flag(1'b0);
        read_flag(1'b1);
        configure(16'd2, 16'd4, 2'b11);
        read_flag(1'b0);
        read_flag(1'b1);
        read_flag(1'b1);
        repeat (3) scan(2'b11);
        repeat (2) scan(2'b01);
        scan(2'b00);
        repeat (6) scan(2'b10);
        read_flag(1'b1);
        read_flag(1'b0);
        configure(16'd1, 16'd1, 2'b00);
        scan(2'b01);
        read_flag(1'b0);
        scan(2'b01);
        scan(2'b01);
        read_flag(1'b0);

        for (int p = 0; p < PHASES; p++)
        begin
            configure(hold_plan[p], max_plan[p], keys_t'($urandom_range(0, 3)));
            calm = (p % 3 == 2);
            random_phase(PHASE_ITEMS);
        end
        calm = 1'b0;
        settle();

        if (tracker.mismatches == 0 && tracker.awaited_status.size() == 0)
            $display("tb_key_press_debouncer: clean");
        else
            $display("tb_key_press_debouncer: errors");
        $finish;
    end

endmodule
